>>> src/sha_pkg.sv
// Shared types, constants and the rotate function for the SHA-256 digest block.
package sha_pkg;

   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned DigestWords = 8;
   localparam int unsigned Rounds      = 64;

   typedef logic [31:0] word_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       absorb;     // write request byte into block
      logic       pad_write;  // write padding byte at pad_index
      logic       pad_marker; // padding byte is the 0x80 marker
      logic       pad_length; // padding byte is a length byte
      logic [5:0] pad_index;
      logic       load;       // latch schedule and working vars from block
      logic       round;      // run one round
      logic [5:0] round_num;
      logic       fold;       // add working vars into hash
      logic       restart;    // reload initial hash, clear counts
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic       block_full;
      logic [5:0] fill;
   } status_type;

   localparam word_type InitH [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

>>> src/sha_if.sv
// Valid/ready channel interfaces for request bytes and response words.
interface sha_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source  (output valid, msg_byte, byte_present, end_of_message, input ready);
   modport sink    (input valid, msg_byte, byte_present, end_of_message, output ready);
   modport monitor (input valid, ready, msg_byte, byte_present, end_of_message);
endinterface

interface sha_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source  (output valid, digest_word, word_index, last_word, input ready);
   modport sink    (input valid, digest_word, word_index, last_word, output ready);
   modport monitor (input valid, ready, digest_word, word_index, last_word);
endinterface

>>> src/sha_datapath.sv
// Block buffer, message schedule, round logic and hash state.
module sha_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::cmd_type    cmd,
   input  logic [7:0]          in_byte,
   input  logic [2:0]          out_index,
   output sha_pkg::status_type status,
   output logic [31:0]         hash_word
);
   import sha_pkg::*;

   word_type    block_ff [16];
   logic [6:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   word_type    hash_ff [DigestWords];
   word_type    hash_in [DigestWords];
   word_type    sched_ff [16];
   word_type    sched_in [16];
   word_type    var_ff [8];
   word_type    var_in [8];
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic        wr_en;
   logic [7:0]  len_byte;

   // Length byte for the tail of the final block
   always_comb begin
      len_byte = 8'h00;
      if (cmd.pad_index >= 6'd56)
         len_byte = bits_ff[(7 - (cmd.pad_index - 6'd56)) * 8 +: 8];
   end

   // Select block write source
   always_comb begin
      wr_en   = cmd.absorb | cmd.pad_write;
      wr_addr = cmd.absorb ? fill_ff[5:0] : cmd.pad_index;
      if (cmd.absorb)
         wr_data = in_byte;
      else if (cmd.pad_marker)
         wr_data = 8'h80;
      else if (cmd.pad_length)
         wr_data = len_byte;
      else
         wr_data = 8'h00;
   end

   // Write one byte lane of the block, big-endian within each word
   always_ff @(posedge clock) begin
      if (wr_en)
         block_ff[wr_addr[5:2]][(3 - wr_addr[1:0]) * 8 +: 8] <= wr_data;
   end

   assign status.fill       = fill_ff[5:0];
   assign status.block_full = fill_ff[6];

   // Fill and length counters
   always_comb begin
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.restart) begin
         fill_in = '0;
         bits_in = '0;
      end else if (cmd.absorb) begin
         fill_in = fill_ff + 7'd1;
         bits_in = bits_ff + 64'd8;
      end else if (cmd.load && fill_ff[6]) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
      end
   end

   // Round logic: schedule update and compression step
   always_comb begin
      word_type w, w2, w7, w15, w16, s0, s1, t1, t2, a, b, c, e, f, g;
      for (int i = 0; i < 16; i++) sched_in[i] = sched_ff[i];
      for (int i = 0; i < 8; i++) var_in[i] = var_ff[i];
      for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i];
      w2  = sched_ff[4'(cmd.round_num - 6'd2)];
      w7  = sched_ff[4'(cmd.round_num - 6'd7)];
      w15 = sched_ff[4'(cmd.round_num - 6'd15)];
      w16 = sched_ff[cmd.round_num[3:0]];
      s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      w   = (cmd.round_num < 6'd16) ? w16 : (s1 + w7 + s0 + w16);
      a = var_ff[0]; b = var_ff[1]; c = var_ff[2];
      e = var_ff[4]; f = var_ff[5]; g = var_ff[6];
      t1 = var_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundK[cmd.round_num] + w;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      if (cmd.load) begin
         for (int i = 0; i < 16; i++) sched_in[i] = block_ff[i];
         for (int i = 0; i < 8; i++) var_in[i] = hash_ff[i];
      end else if (cmd.round) begin
         sched_in[cmd.round_num[3:0]] = w;
         var_in[7] = g;
         var_in[6] = f;
         var_in[5] = e;
         var_in[4] = var_ff[3] + t1;
         var_in[3] = c;
         var_in[2] = b;
         var_in[1] = a;
         var_in[0] = t1 + t2;
      end
      if (cmd.restart) begin
         for (int i = 0; i < 8; i++) hash_in[i] = InitH[i];
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + var_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) sched_ff[i] <= sched_in[i];
      for (int i = 0; i < 8; i++) var_ff[i] <= var_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitH[i];
      end else begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_in[i];
      end
   end

   assign hash_word = hash_ff[out_index];

   // Fill never passes a full block
   assert property (@(posedge clock) disable iff (reset)
      fill_ff[6] |-> fill_ff[5:0] == 6'd0)
      else $error("block fill beyond one block");
   // A full block is never written before it is loaded
   assert property (@(posedge clock) disable iff (reset)
      fill_ff[6] |-> !cmd.absorb)
      else $error("byte written into a full block");
   // Restart leaves counters clear
   assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> fill_ff == '0 && bits_ff == '0)
      else $error("restart left counts set");
endmodule

>>> src/sha_control.sv
// Controller sequencing absorb, compression, padding and digest output.
module sha_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_byte_present,
   input  logic                req_end_of_message,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          out_index,
   output logic                out_last,
   input  sha_pkg::status_type status,
   output sha_pkg::cmd_type    cmd
);
   import sha_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] count_ff, count_in;
   logic       final_ff, final_in;   // message end pending
   logic       tail_ff, tail_in;     // current pad block holds the length
   logic       padded_ff, padded_in; // 0x80 marker already placed
   logic       accept;

   assign accept = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      final_in  = final_ff;
      tail_in   = tail_ff;
      padded_in = padded_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               final_in  = req_end_of_message;
               padded_in = 1'b0;
               if (req_byte_present && status.fill == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
                  count_in = '0;
                  tail_in  = (status.fill + 6'(req_byte_present)) < 6'd56;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
            count_in = '0;
         end
         ST_ROUND: begin
            count_in = count_ff + 6'd1;
            if (count_ff == 6'd63)
               state_in = ST_FOLD;
         end
         ST_FOLD: begin
            count_in = '0;
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (padded_ff && tail_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
               tail_in  = 1'b1;
            end
         end
         ST_PAD: begin
            count_in = count_ff + 6'd1;
            if (count_ff == status.fill) padded_in = 1'b1;
            if (count_ff == 6'd63)
               state_in = ST_LOAD;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               count_in = count_ff + 6'd1;
               if (count_ff[2:0] == 3'd7) begin
                  state_in = ST_IDLE;
                  final_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd           = '0;
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = (state_ff == ST_EMIT);
      out_index     = count_ff[2:0];
      out_last      = (count_ff[2:0] == 3'd7);
      cmd.round_num = count_ff;
      cmd.pad_index = count_ff;
      unique case (state_ff)
         ST_IDLE:  cmd.absorb = accept && req_byte_present;
         ST_LOAD:  cmd.load = 1'b1;
         ST_ROUND: cmd.round = 1'b1;
         ST_FOLD:  cmd.fold = 1'b1;
         // Write from the fill point on, or the whole block once the marker is placed
         ST_PAD: begin
            cmd.pad_write  = (count_ff >= status.fill) || padded_ff;
            cmd.pad_marker = !padded_ff && count_ff == status.fill;
            cmd.pad_length = tail_ff && count_ff >= 6'd56;
         end
         ST_EMIT:  cmd.restart = rsp_ready && count_ff[2:0] == 3'd7;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         final_ff  <= 1'b0;
         tail_ff   <= 1'b0;
         padded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         final_ff  <= final_in;
         tail_ff   <= tail_in;
         padded_ff <= padded_in;
      end
   end

   // Load leads into the round state with the round count cleared
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_ROUND && count_ff == 6'd0)
      else $error("round count not cleared on load");
   // Digest only after a finished message
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> final_ff)
      else $error("digest emitted without end of message");
   // No requests taken while the digest is output
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request accepted during output");
endmodule

>>> src/sha256_message_digest.sv
// Top level of the SHA-256 digest block: controller plus datapath.
// A byte that does not fill the block is absorbed and the block stays ready;
// one that fills a block adds a load, 64 rounds from the single round unit and
// a fold. End of message pads each final block (one or two), then loads,
// rounds and folds it; eight digest words follow at one per accepted cycle.
// Synchronous active-high reset restores the initial hash and clears the counts.
module sha256_message_digest (
   input logic    clock,
   input logic    reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   import sha_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [2:0] out_index;
   logic       out_last;
   logic [31:0] hash_word;

   sha_control u_control (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req.valid),
      .req_ready          (req.ready),
      .req_byte_present   (req.byte_present),
      .req_end_of_message (req.end_of_message),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .out_index          (out_index),
      .out_last           (out_last),
      .status             (status),
      .cmd                (cmd)
   );

   sha_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_byte   (req.msg_byte),
      .out_index (out_index),
      .status    (status),
      .hash_word (hash_word)
   );

   assign rsp.digest_word = hash_word;
   assign rsp.word_index  = out_index;
   assign rsp.last_word   = out_last;
endmodule
